// ===== design/pesr_pkg.sv =====
// Package: shared types, constants and register indexes for the palette shade/pack block.
`timescale 1ns / 1ps
`default_nettype none
package pesr_pkg;

	localparam int unsigned CH_W    = 8;
	localparam int unsigned SCALE_W = 16;
	localparam int unsigned FMT_W   = 21;
	localparam int unsigned COLOR_W = 16;
	localparam int unsigned SUM_W   = 18;  // 1000 * 255 fits
	localparam int unsigned PROD_W  = SCALE_W + CH_W;
	localparam int unsigned CFG_IDX_W = 3;

	// luminance weights, sum is divided by 1000
	localparam logic [9:0] LUM_WR = 10'd299;
	localparam logic [9:0] LUM_WG = 10'd587;
	localparam logic [9:0] LUM_WB = 10'd114;
	localparam logic [9:0] LUM_DIV = 10'd1000;

	// floor(x/1000) estimate: (x * 1048) >> 20 is low by at most one
	localparam logic [10:0] RECIP_1000 = 11'd1048;
	localparam int unsigned RECIP_SH   = 20;

	localparam logic [COLOR_W-1:0] BLACK_SUB = 16'h0001;

	localparam logic [SCALE_W-1:0] SCALE_RST = 16'd256;
	localparam logic [FMT_W-1:0]   RED_FMT_RST   = 21'h08F800;
	localparam logic [FMT_W-1:0]   GREEN_FMT_RST = 21'h0307E0;
	localparam logic [FMT_W-1:0]   BLUE_FMT_RST  = 21'h1D001F;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RED_SCALE   = 3'd0,
		CFG_GREEN_SCALE = 3'd1,
		CFG_BLUE_SCALE  = 3'd2,
		CFG_MONO_MODE   = 3'd3,
		CFG_RED_FMT     = 3'd4,
		CFG_GREEN_FMT   = 3'd5,
		CFG_BLUE_FMT    = 3'd6
	} cfg_idx_t;

	typedef logic [CH_W-1:0]    chan_t;
	typedef logic [FMT_W-1:0]   fmt_t;
	typedef logic [COLOR_W-1:0] color_t;

endpackage
`default_nettype wire

// ===== design/pesr_if.sv =====
// Interfaces: palette entry input channel and packed color output channel.
`timescale 1ns / 1ps
`default_nettype none
interface pesr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in,
		input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in,
		output ready);
endinterface

interface pesr_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] packed_color;

	modport source (output valid, output packed_color, input ready);
	modport sink (input valid, input packed_color, output ready);
endinterface
`default_nettype wire

// ===== design/pesr_place.sv =====
// Channel placement: saturate a scaled channel, shift by the signed format shift, mask.
`timescale 1ns / 1ps
`default_nettype none
module pesr_place (
	input  wire logic [pesr_pkg::PROD_W-1:0] prod,
	input  wire pesr_pkg::fmt_t              fmt,
	output pesr_pkg::chan_t                  shade,
	output pesr_pkg::color_t                 field
);
	import pesr_pkg::*;

	logic [4:0]          sh;
	logic [4:0]          amt;
	logic [PROD_W-CH_W-CH_W-1:0] upper;
	logic [COLOR_W+CH_W-1:0] lshift;
	color_t              placed;

	always_comb begin
		// prod / 256, saturate at 255
		upper = prod[PROD_W-1:CH_W + CH_W];
		shade = (upper != '0) ? 8'hFF : prod[CH_W + CH_W - 1:CH_W];
		sh    = fmt[FMT_W-1:COLOR_W];
		amt   = 5'(5'd0 - sh);  // magnitude of a negative shift, 1..16
		lshift = {{COLOR_W{1'b0}}, shade} << sh[3:0];
		if (sh[4]) begin
			placed = COLOR_W'({{COLOR_W-CH_W{1'b0}}, shade} >> amt);
		end else begin
			placed = lshift[COLOR_W-1:0];
		end
		field = placed & fmt[COLOR_W-1:0];
	end

endmodule
`default_nettype wire

// ===== design/palette_entry_shade_to_rgb16.sv =====
// Top level: five-stage pipeline that shades a palette entry and packs it to 16 bits.
`timescale 1ns / 1ps
`default_nettype none
// Usage notes
//  in_ch  : one palette entry (red_in, green_in, blue_in) per item, valid/ready.
//  out_ch : one packed_color per item, valid/ready, same order as the inputs.
//  cfg_*  : write-only registers, written when cfg_we is high at a clock edge.
//           Index 0..2 scales, 3 mono_mode, 4..6 formats; index 7 is ignored.
//           Write only while no item is in flight.
// Pipeline (one item per clock sustained while the output is not stalled):
//  s1  luminance weighted sum 299r + 587g + 114b
//  s2  reciprocal multiply, estimate of sum/1000 (low by at most one)
//  s3  remainder check corrects the estimate to the exact luminance
//  s4  scale * channel (or scale * luminance in mono mode), 16x8 multipliers
//  s5  saturate, shift, mask, OR, black substitution -> output register
// Throughput is set by the output handshake; every stage is registered.
// Every stage has its own valid bit and loads when it is empty or the stage
// after it moves, so bubbles collapse and in_ch.ready stays high while the
// output register waits, until all five stages hold items.
// Reset clears all valid bits and puts the registers at gain 1.0, color
// mode, RGB565 packing. A stalled receiver freezes only full stages; no item
// is dropped or repeated.
module palette_entry_shade_to_rgb16 (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	pesr_in_if.sink                            in_ch,
	pesr_out_if.source                         out_ch,
	input  wire logic                          cfg_we,
	input  wire logic [pesr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pesr_pkg::FMT_W-1:0]    cfg_data
);
	import pesr_pkg::*;

	// configuration registers
	logic [SCALE_W-1:0] red_scale_q, green_scale_q, blue_scale_q;
	logic               mono_q;
	fmt_t               red_fmt_q, green_fmt_q, blue_fmt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_scale_q   <= SCALE_RST;
			green_scale_q <= SCALE_RST;
			blue_scale_q  <= SCALE_RST;
			mono_q        <= 1'b0;
			red_fmt_q     <= RED_FMT_RST;
			green_fmt_q   <= GREEN_FMT_RST;
			blue_fmt_q    <= BLUE_FMT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_RED_SCALE:   red_scale_q   <= cfg_data[SCALE_W-1:0];
				CFG_GREEN_SCALE: green_scale_q <= cfg_data[SCALE_W-1:0];
				CFG_BLUE_SCALE:  blue_scale_q  <= cfg_data[SCALE_W-1:0];
				CFG_MONO_MODE:   mono_q        <= cfg_data[0];
				CFG_RED_FMT:     red_fmt_q     <= cfg_data;
				CFG_GREEN_FMT:   green_fmt_q   <= cfg_data;
				CFG_BLUE_FMT:    blue_fmt_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage valid bits and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	assign en_s5 = !v_s5 || out_ch.ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ch.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_ch.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// s1: weighted sum
	chan_t            r_s1, g_s1, b_s1;
	logic [SUM_W-1:0] sum_s1;
	always_ff @(posedge clk) begin
		if (en_s1) begin
			r_s1   <= in_ch.red_in;
			g_s1   <= in_ch.green_in;
			b_s1   <= in_ch.blue_in;
			sum_s1 <= SUM_W'(in_ch.red_in * LUM_WR) + SUM_W'(in_ch.green_in * LUM_WG)
				+ SUM_W'(in_ch.blue_in * LUM_WB);
		end
	end

	// s2: quotient estimate
	chan_t                        r_s2, g_s2, b_s2, q0_s2;
	logic [SUM_W-1:0]             sum_s2;
	logic [SUM_W+11-1:0]          recip_prod;
	assign recip_prod = (SUM_W + 11)'(sum_s1) * (SUM_W + 11)'(RECIP_1000);
	always_ff @(posedge clk) begin
		if (en_s2) begin
			r_s2   <= r_s1;
			g_s2   <= g_s1;
			b_s2   <= b_s1;
			sum_s2 <= sum_s1;
			q0_s2  <= recip_prod[RECIP_SH + CH_W - 1:RECIP_SH];
		end
	end

	// s3: correct estimate to exact floor(sum/1000)
	chan_t            r_s3, g_s3, b_s3, lum_s3;
	logic [SUM_W-1:0] rem;
	assign rem = sum_s2 - SUM_W'(q0_s2 * LUM_DIV);
	always_ff @(posedge clk) begin
		if (en_s3) begin
			r_s3   <= r_s2;
			g_s3   <= g_s2;
			b_s3   <= b_s2;
			lum_s3 <= (rem >= SUM_W'(LUM_DIV)) ? q0_s2 + 8'd1 : q0_s2;
		end
	end

	// s4: gain multiply
	logic [PROD_W-1:0] rp_s4, gp_s4, bp_s4;
	chan_t             r_src, g_src, b_src;
	always_comb begin
		r_src = mono_q ? lum_s3 : r_s3;
		g_src = mono_q ? lum_s3 : g_s3;
		b_src = mono_q ? lum_s3 : b_s3;
	end
	always_ff @(posedge clk) begin
		if (en_s4) begin
			rp_s4 <= PROD_W'(red_scale_q) * PROD_W'(r_src);
			gp_s4 <= PROD_W'(green_scale_q) * PROD_W'(g_src);
			bp_s4 <= PROD_W'(blue_scale_q) * PROD_W'(b_src);
		end
	end

	// s5: place, pack, substitute for black collisions
	chan_t  r_sh, g_sh, b_sh;
	color_t r_fld, g_fld, b_fld, word;
	color_t packed_s5;

	pesr_place u_place_r (.prod(rp_s4), .fmt(red_fmt_q),   .shade(r_sh), .field(r_fld));
	pesr_place u_place_g (.prod(gp_s4), .fmt(green_fmt_q), .shade(g_sh), .field(g_fld));
	pesr_place u_place_b (.prod(bp_s4), .fmt(blue_fmt_q),  .shade(b_sh), .field(b_fld));

	always_comb begin
		word = r_fld | g_fld | b_fld;
		if (word == '0 && (r_sh != '0 || g_sh != '0 || b_sh != '0)) begin
			word = BLACK_SUB;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			packed_s5 <= word;
		end
	end

	assign out_ch.valid        = v_s5;
	assign out_ch.packed_color = packed_s5;

endmodule
`default_nettype wire
